>>> rtl/core/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg: shared definitions of the voltage loop compensator
// Widths, scaling constants, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package vlc_pkg;

  // Operand and product widths of the shared multiplier
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // Weighted sum and its magnitude
  localparam int SUM_W  = 34;
  localparam int MAG_W  = SUM_W - 1;
  localparam int DCNT_W = $clog2(MAG_W + 1);

  // Field widths
  localparam int ADC_W  = 10;
  localparam int MV_W   = 13;
  localparam int ERR_W  = 17;
  localparam int WORD_W = 16;
  localparam int OFS_W  = 12;
  localparam int IDX_W  = 3;

  // Millivolt scaling: sample * 5000 / 1023, the division as a reciprocal
  // multiply. ceil(2^33 / 1023) is exact for every product below 2^23.
  localparam logic [MUL_W-1:0] MV_FULL_SCALE = MUL_W'(5000);
  localparam logic [MUL_W-1:0] ADC_RECIP     = MUL_W'(8396809);
  localparam int               RECIP_SHIFT   = 33;

  // Register reset values
  localparam logic [WORD_W-1:0] REF_RESET     = WORD_W'(1200);
  localparam logic [OFS_W-1:0]  OFS_RESET     = OFS_W'(200);
  localparam logic [WORD_W-1:0] DIVISOR_RESET = WORD_W'(1);
  localparam logic [WORD_W-1:0] TOP_RESET     = WORD_W'(199);

  typedef enum logic [IDX_W-1:0] {
    REG_REFERENCE   = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_GAIN_ERR    = 3'd2,
    REG_GAIN_LAST   = 3'd3,
    REG_GAIN_ACTION = 3'd4,
    REG_DIVISOR     = 3'd5,
    REG_PWM_TOP     = 3'd6
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RECIP,
    ST_ERROR,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/vlc_mul.sv
// ----------------------------------------------------------------------------
// vlc_mul: shared signed multiplier
// One registered signed product per cycle; the sequencer picks the operands.
// ----------------------------------------------------------------------------
module vlc_mul (
  input  logic                             clk,
  input  logic signed [vlc_pkg::MUL_W-1:0]  a,
  input  logic signed [vlc_pkg::MUL_W-1:0]  b,
  output logic signed [vlc_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

>>> rtl/core/vlc_div.sv
// ----------------------------------------------------------------------------
// vlc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over a MAG_W-bit dividend.
// ----------------------------------------------------------------------------
module vlc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [vlc_pkg::MAG_W-1:0]        dividend,
  input  logic [vlc_pkg::WORD_W-1:0]       divisor,
  output logic                             done,
  output logic [vlc_pkg::MAG_W-1:0]        quotient
);

  logic                          running;
  logic [vlc_pkg::DCNT_W-1:0]    cnt;
  logic [vlc_pkg::WORD_W-1:0]    rem;
  logic [vlc_pkg::WORD_W-1:0]    dvs;
  logic [vlc_pkg::MAG_W-1:0]     quo;
  logic [vlc_pkg::WORD_W:0]      trial;
  logic                          fits;

  assign trial    = {rem, quo[vlc_pkg::MAG_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= vlc_pkg::DCNT_W'(vlc_pkg::MAG_W - 1);
        rem     <= '0;
        dvs     <= divisor;
        quo     <= dividend;
      end else if (running) begin
        // shift in the next dividend bit, subtract where it fits
        if (fits) begin
          rem <= vlc_pkg::WORD_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[vlc_pkg::WORD_W-1:0];
        end
        quo <= {quo[vlc_pkg::MAG_W-2:0], fits};
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - vlc_pkg::DCNT_W'(1);
        end
      end
    end
  end

endmodule

>>> rtl/core/voltage_loop_compensator.sv
// A negative weighted sum skips the divider; a new sample is taken only once
// the previous result has been loaded into the output register.
// The 33-step divider divides the weighted sum; the shared
// multiplier takes one product per cycle for scaling and the three gains.
// Reset (synchronous, active high) restores register defaults and clears
// the previous error and action.
// ----------------------------------------------------------------------------
// voltage_loop_compensator: incremental PI controller for a voltage loop
// Scales an ADC sample to millivolts, forms the error against the reference
// and computes the clamped PWM compare value with one shared multiplier and
// an iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
module voltage_loop_compensator (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vlc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [vlc_pkg::WORD_W-1:0]        cfg_data,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vlc_pkg::ADC_W-1:0]         adc_sample,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vlc_pkg::WORD_W-1:0]        pwm_compare,
  output logic [vlc_pkg::MV_W-1:0]          measured_mv
);

  vlc_pkg::state_t state, state_next;

  // configuration registers
  logic [vlc_pkg::WORD_W-1:0]  reference_value;
  logic [vlc_pkg::OFS_W-1:0]   offset_mv;
  logic [vlc_pkg::WORD_W-1:0]  gain_error_now;
  logic [vlc_pkg::WORD_W-1:0]  gain_error_last;
  logic [vlc_pkg::WORD_W-1:0]  gain_action_last;
  logic [vlc_pkg::WORD_W-1:0]  gain_divisor;
  logic [vlc_pkg::WORD_W-1:0]  pwm_top;

  // loop state
  logic [vlc_pkg::ERR_W-1:0]   last_error;
  logic [vlc_pkg::WORD_W-1:0]  last_action;

  // working registers
  logic [vlc_pkg::ADC_W-1:0]   sample;
  logic [vlc_pkg::MV_W-1:0]    mv;
  logic [vlc_pkg::ERR_W-1:0]   error;
  logic [vlc_pkg::SUM_W-1:0]   acc;
  logic [vlc_pkg::WORD_W-1:0]  action;

  logic signed [vlc_pkg::MUL_W-1:0]  mul_a;
  logic signed [vlc_pkg::MUL_W-1:0]  mul_b;
  logic signed [vlc_pkg::PROD_W-1:0] prod;

  logic                              div_start;
  logic                              div_done;
  logic [vlc_pkg::MAG_W-1:0]         quotient;
  logic [vlc_pkg::WORD_W-1:0]        div_divisor;

  logic                              load_out;
  logic [vlc_pkg::MV_W-1:0]          mv_scaled;
  logic [vlc_pkg::MV_W:0]            mv_offset;
  logic [vlc_pkg::ERR_W-1:0]         error_next;
  logic [vlc_pkg::SUM_W-1:0]         prod_sum;
  logic [vlc_pkg::WORD_W-1:0]        action_clamped;

  assign cfg_ready = 1'b1;

  vlc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  vlc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc[vlc_pkg::MAG_W-1:0]),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // datapath helpers
  assign mv_scaled   = prod[vlc_pkg::RECIP_SHIFT +: vlc_pkg::MV_W];
  assign mv_offset   = {2'b00, offset_mv} + {1'b0, mv_scaled};
  assign error_next  = {reference_value[vlc_pkg::WORD_W-1], reference_value}
                     - {2'b00, mv_offset, 1'b0};
  assign prod_sum    = prod[vlc_pkg::SUM_W-1:0];
  assign div_divisor = (gain_divisor == '0) ? vlc_pkg::WORD_W'(1) : gain_divisor;
  assign action_clamped = (quotient > {{(vlc_pkg::MAG_W - vlc_pkg::WORD_W){1'b0}}, pwm_top})
                        ? pwm_top : quotient[vlc_pkg::WORD_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      vlc_pkg::ST_IDLE:  if (in_valid) state_next = vlc_pkg::ST_SCALE;
      vlc_pkg::ST_SCALE: state_next = vlc_pkg::ST_RECIP;
      vlc_pkg::ST_RECIP: state_next = vlc_pkg::ST_ERROR;
      vlc_pkg::ST_ERROR: state_next = vlc_pkg::ST_MUL0;
      vlc_pkg::ST_MUL0:  state_next = vlc_pkg::ST_MUL1;
      vlc_pkg::ST_MUL1:  state_next = vlc_pkg::ST_MUL2;
      vlc_pkg::ST_MUL2:  state_next = vlc_pkg::ST_ACC;
      vlc_pkg::ST_ACC:   state_next = vlc_pkg::ST_CHECK;
      vlc_pkg::ST_CHECK: begin
        // a negative sum truncates to zero or below and clamps to zero
        if (acc[vlc_pkg::SUM_W-1]) state_next = vlc_pkg::ST_DONE;
        else                       state_next = vlc_pkg::ST_DIV;
      end
      vlc_pkg::ST_DIV:   if (div_done) state_next = vlc_pkg::ST_DONE;
      vlc_pkg::ST_DONE:  if (!out_valid || !out_stall) state_next = vlc_pkg::ST_IDLE;
      default:           state_next = vlc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state)
      vlc_pkg::ST_IDLE:  in_stall = 1'b0;
      vlc_pkg::ST_SCALE: begin
        mul_a = {{(vlc_pkg::MUL_W - vlc_pkg::ADC_W){1'b0}}, sample};
        mul_b = vlc_pkg::MV_FULL_SCALE;
      end
      vlc_pkg::ST_RECIP: begin
        mul_a = prod[vlc_pkg::MUL_W-1:0];
        mul_b = vlc_pkg::ADC_RECIP;
      end
      vlc_pkg::ST_MUL0: begin
        mul_a = {{(vlc_pkg::MUL_W - vlc_pkg::ERR_W){error[vlc_pkg::ERR_W-1]}}, error};
        mul_b = {{(vlc_pkg::MUL_W - vlc_pkg::WORD_W){gain_error_now[vlc_pkg::WORD_W-1]}},
                 gain_error_now};
      end
      vlc_pkg::ST_MUL1: begin
        mul_a = {{(vlc_pkg::MUL_W - vlc_pkg::ERR_W){last_error[vlc_pkg::ERR_W-1]}},
                 last_error};
        mul_b = {{(vlc_pkg::MUL_W - vlc_pkg::WORD_W){gain_error_last[vlc_pkg::WORD_W-1]}},
                 gain_error_last};
      end
      vlc_pkg::ST_MUL2: begin
        mul_a = {{(vlc_pkg::MUL_W - vlc_pkg::WORD_W){1'b0}}, last_action};
        mul_b = {{(vlc_pkg::MUL_W - vlc_pkg::WORD_W){gain_action_last[vlc_pkg::WORD_W-1]}},
                 gain_action_last};
      end
      vlc_pkg::ST_CHECK: div_start = !acc[vlc_pkg::SUM_W-1];
      vlc_pkg::ST_DONE:  load_out  = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= vlc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_value  <= vlc_pkg::REF_RESET;
      offset_mv        <= vlc_pkg::OFS_RESET;
      gain_error_now   <= '0;
      gain_error_last  <= '0;
      gain_action_last <= '0;
      gain_divisor     <= vlc_pkg::DIVISOR_RESET;
      pwm_top          <= vlc_pkg::TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (vlc_pkg::cfg_reg_t'(cfg_index))
        vlc_pkg::REG_REFERENCE:   reference_value  <= cfg_data;
        vlc_pkg::REG_OFFSET:      offset_mv        <= cfg_data[vlc_pkg::OFS_W-1:0];
        vlc_pkg::REG_GAIN_ERR:    gain_error_now   <= cfg_data;
        vlc_pkg::REG_GAIN_LAST:   gain_error_last  <= cfg_data;
        vlc_pkg::REG_GAIN_ACTION: gain_action_last <= cfg_data;
        vlc_pkg::REG_DIVISOR:     gain_divisor     <= cfg_data;
        vlc_pkg::REG_PWM_TOP:     pwm_top          <= cfg_data;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      vlc_pkg::ST_IDLE:  if (in_valid) sample <= adc_sample;
      vlc_pkg::ST_ERROR: begin
        mv    <= mv_scaled;
        error <= error_next;
      end
      vlc_pkg::ST_MUL1:  acc <= prod_sum;
      vlc_pkg::ST_MUL2:  acc <= acc + prod_sum;
      vlc_pkg::ST_ACC:   acc <= acc + prod_sum;
      vlc_pkg::ST_CHECK: action <= '0;
      vlc_pkg::ST_DIV:   if (div_done) action <= action_clamped;
      default: ;
    endcase
  end

  // loop state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error  <= '0;
      last_action <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        last_error  <= error;
        last_action <= action;
        out_valid   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pwm_compare <= action;
      measured_mv <= mv;
    end
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the voltage loop compensator
// Sends ADC samples under a range of register settings and idling patterns,
// predicts each PWM compare and millivolt value with an in-bench controller
// model, and compares every returned item against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int                         MV_SPAN     = 5000;
  localparam int                         ADC_SPAN    = 1023;
  localparam logic [vlc_pkg::IDX_W-1:0]  REG_UNUSED  = 3'd7;
  localparam int                         CYCLE_LIMIT = 1000000;
  localparam int                         TAIL_CYCLES = 100;

  typedef struct packed {
    logic [vlc_pkg::WORD_W-1:0] compare;
    logic [vlc_pkg::MV_W-1:0]   mv;
  } loop_result_t;

  logic                       clk;
  logic                       rst        = 1'b1;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [vlc_pkg::IDX_W-1:0]  cfg_index  = '0;
  logic [vlc_pkg::WORD_W-1:0] cfg_data   = '0;
  logic                       in_valid   = 1'b0;
  logic                       in_stall;
  logic [vlc_pkg::ADC_W-1:0]  adc_sample = '0;
  logic                       out_valid;
  logic                       out_stall  = 1'b0;
  logic [vlc_pkg::WORD_W-1:0] pwm_compare;
  logic [vlc_pkg::MV_W-1:0]   measured_mv;

  // controller model: register shadow and loop history
  logic signed [vlc_pkg::WORD_W-1:0] set_reference   = vlc_pkg::WORD_W'(1200);
  logic [vlc_pkg::OFS_W-1:0]         set_offset      = vlc_pkg::OFS_W'(200);
  logic signed [vlc_pkg::WORD_W-1:0] set_gain_now    = '0;
  logic signed [vlc_pkg::WORD_W-1:0] set_gain_last   = '0;
  logic signed [vlc_pkg::WORD_W-1:0] set_gain_action = '0;
  logic [vlc_pkg::WORD_W-1:0]        set_divisor     = vlc_pkg::WORD_W'(1);
  logic [vlc_pkg::WORD_W-1:0]        set_top         = vlc_pkg::WORD_W'(199);
  logic signed [vlc_pkg::ERR_W-1:0]  prev_error      = '0;
  logic [vlc_pkg::WORD_W-1:0]        prev_action     = '0;

  loop_result_t pending_results[$];
  loop_result_t want;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int samples_sent     = 0;
  int results_checked  = 0;
  int settings_applied = 0;
  int mismatches       = 0;
  int cycle_count      = 0;

  voltage_loop_compensator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .adc_sample  (adc_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pwm_compare (pwm_compare),
    .measured_mv (measured_mv)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one loop tick: scale, form the error, weigh, divide, clamp
  function automatic loop_result_t loop_update(input logic [vlc_pkg::ADC_W-1:0] s);
    loop_result_t r;
    int           mv;
    int           err;
    longint       acc;
    longint       den;
    longint       act;
    mv  = int'(s) * MV_SPAN / ADC_SPAN;
    err = int'(set_reference) - 2 * (int'(set_offset) + mv);
    acc = longint'(set_gain_now) * err
        + longint'(set_gain_last) * longint'(prev_error)
        + longint'(set_gain_action) * longint'(prev_action);
    den = (set_divisor == '0) ? 64'sd1 : longint'(set_divisor);
    act = acc / den;
    if (act < 0)
      act = 0;
    else if (act > longint'(set_top))
      act = longint'(set_top);
    prev_error  = vlc_pkg::ERR_W'(err);
    prev_action = vlc_pkg::WORD_W'(act);
    r.compare   = vlc_pkg::WORD_W'(act);
    r.mv        = vlc_pkg::MV_W'(mv);
    return r;
  endfunction

  // pick a value in lo..hi, hitting either end a quarter of the time
  function automatic logic [vlc_pkg::WORD_W-1:0] rand_word(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0:       return vlc_pkg::WORD_W'(lo);
      1:       return vlc_pkg::WORD_W'(hi);
      default: return vlc_pkg::WORD_W'(lo + int'($urandom_range(hi - lo, 0)));
    endcase
  endfunction

  task automatic push_sample(input logic [vlc_pkg::ADC_W-1:0] s);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    adc_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(loop_update(s));
    samples_sent++;
  endtask

  // hold off the sender until every predicted item has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic cfg_write(input logic [vlc_pkg::IDX_W-1:0] idx,
                           input logic [vlc_pkg::WORD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      vlc_pkg::REG_REFERENCE:   set_reference   = value;
      vlc_pkg::REG_OFFSET:      set_offset      = value[vlc_pkg::OFS_W-1:0];
      vlc_pkg::REG_GAIN_ERR:    set_gain_now    = value;
      vlc_pkg::REG_GAIN_LAST:   set_gain_last   = value;
      vlc_pkg::REG_GAIN_ACTION: set_gain_action = value;
      vlc_pkg::REG_DIVISOR:     set_divisor     = value;
      vlc_pkg::REG_PWM_TOP:     set_top         = value;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [vlc_pkg::WORD_W-1:0] ref_mv, ofs, g_now,
                                g_last, g_action, divisor, top);
    settle();
    cfg_write(vlc_pkg::REG_REFERENCE, ref_mv);
    cfg_write(vlc_pkg::REG_OFFSET, ofs);
    cfg_write(vlc_pkg::REG_GAIN_ERR, g_now);
    cfg_write(vlc_pkg::REG_GAIN_LAST, g_last);
    cfg_write(vlc_pkg::REG_GAIN_ACTION, g_action);
    cfg_write(vlc_pkg::REG_DIVISOR, divisor);
    cfg_write(vlc_pkg::REG_PWM_TOP, top);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic apply_random_settings();
    logic [vlc_pkg::WORD_W-1:0] ofs;
    // junk above the 12-bit offset must be dropped
    ofs = rand_word(0, 4095)
        | (vlc_pkg::WORD_W'($urandom_range(0, 15)) << vlc_pkg::OFS_W);
    if ($urandom_range(0, 3) != 0)
      apply_settings(rand_word(0, 12000), rand_word(0, 1000), rand_word(-512, 512),
                     rand_word(-512, 512), rand_word(-64, 64), rand_word(1, 1024),
                     rand_word(1, 1023));
    else
      apply_settings(rand_word(-32768, 32767), ofs, rand_word(-32768, 32767),
                     rand_word(-32768, 32767), rand_word(-32768, 32767),
                     rand_word(0, 65535), rand_word(0, 65535));
  endtask

  task automatic push_random_samples(input int count);
    logic [vlc_pkg::ADC_W-1:0] s;
    s = vlc_pkg::ADC_W'($urandom_range(0, ADC_SPAN));
    repeat (count) begin
      // half the time a slowly drifting reading, otherwise a jump anywhere in range
      if ($urandom_range(0, 1) == 0)
        s = vlc_pkg::ADC_W'($urandom_range(0, ADC_SPAN));
      else
        s = vlc_pkg::ADC_W'(int'(s) + int'($urandom_range(0, 16)) - 8);
      push_sample(s);
    end
  endtask

  task automatic test_reset_defaults();
    push_sample(vlc_pkg::ADC_W'(0));
    push_sample(vlc_pkg::ADC_W'(ADC_SPAN));
    push_sample(vlc_pkg::ADC_W'(512));
  endtask

  task automatic test_positive_extremes();
    apply_settings(16'h7FFF, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd1, 16'hFFFF);
    push_sample(vlc_pkg::ADC_W'(0));
    push_sample(vlc_pkg::ADC_W'(ADC_SPAN));
    push_sample(vlc_pkg::ADC_W'(1));
    push_sample(vlc_pkg::ADC_W'(0));
  endtask

  // largest negative error: lowest reference, top offset, full-scale sample
  task automatic test_negative_extremes();
    apply_settings(16'h8000, 16'd4095, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd1);
    push_sample(vlc_pkg::ADC_W'(ADC_SPAN));
    push_sample(vlc_pkg::ADC_W'(ADC_SPAN));
    push_sample(vlc_pkg::ADC_W'(0));
    push_sample(vlc_pkg::ADC_W'(511));
  endtask

  task automatic test_zero_divisor_and_top();
    apply_settings(16'd12000, 16'd0, 16'd7, 16'hFFFD, 16'd1, 16'd0, 16'd0);
    push_sample(vlc_pkg::ADC_W'(0));
    push_sample(vlc_pkg::ADC_W'(300));
    apply_settings(16'd12000, 16'd0, 16'd7, 16'hFFFD, 16'd1, 16'd0, 16'hFFFF);
    push_sample(vlc_pkg::ADC_W'(0));
    push_sample(vlc_pkg::ADC_W'(300));
    push_sample(vlc_pkg::ADC_W'(1022));
  endtask

  task automatic test_unknown_register();
    settle();
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_valid <= 1'b0;
    push_sample(vlc_pkg::ADC_W'(100));
    push_sample(vlc_pkg::ADC_W'(900));
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 14; phase++) begin
      // every fourth phase runs with no idling on either side
      gaps_on  = (phase % 4 != 3);
      stall_on = (phase % 4 != 3);
      apply_random_settings();
      push_random_samples(130);
    end
  endtask

  task automatic test_quiet_tail();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    apply_random_settings();
    push_random_samples(40);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_positive_extremes();
    test_negative_extremes();
    test_zero_divisor_and_top();
    test_unknown_register();
    test_random_settings();
    test_quiet_tail();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d samples sent under %0d register settings, %0d results checked",
             samples_sent, settings_applied, results_checked);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result-side backpressure in random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item pwm_compare=%0d measured_mv=%0d",
                 $time, pwm_compare, measured_mv);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (pwm_compare !== want.compare) begin
          mismatches++;
          $display("%0t: pwm_compare expected %0d actual %0d",
                   $time, want.compare, pwm_compare);
        end
        if (measured_mv !== want.mv) begin
          mismatches++;
          $display("%0t: measured_mv expected %0d actual %0d",
                   $time, want.mv, measured_mv);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d items outstanding", $time, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
